// ===== hdl/byte_fifo_watermark_flow_control_macros.svh =====
// Assertion helpers, clocked on clk and held off while rst_n is low.
`ifndef BYTE_FIFO_WATERMARK_FLOW_CONTROL_MACROS_SVH
`define BYTE_FIFO_WATERMARK_FLOW_CONTROL_MACROS_SVH

// Same-cycle implication.
`define BFWFC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bfwfc check failed");

// Next-cycle implication.
`define BFWFC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bfwfc check failed");

`endif

// ===== hdl/bfwfc_pkg.sv =====
package bfwfc_pkg;

    localparam int DEPTH     = 4096;
    localparam int AW        = $clog2(DEPTH);
    localparam int MARK_W    = 12;
    localparam int FILL_W    = 12;
    localparam int BYTE_W    = 8;
    localparam int CMD_W     = 2;
    localparam int MODE_W    = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CMP_W     = (AW > MARK_W) ? AW : MARK_W;

    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

    // result word layout, lowest bit up
    localparam int OV_BIT   = 0;
    localparam int OB_LSB   = OV_BIT + 1;
    localparam int TK_BIT   = OB_LSB + BYTE_W;
    localparam int MD_LSB   = TK_BIT + 1;
    localparam int FL_LSB   = MD_LSB + MODE_W;
    localparam int OUT_BITS = FL_LSB + FILL_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_MARK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REFILL_MARK  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RESUME_MARK  = 2'd2;

    localparam logic [MARK_W-1:0] INITIAL_MARK_RST = 12'd409;
    localparam logic [MARK_W-1:0] REFILL_MARK_RST  = 12'd409;
    localparam logic [MARK_W-1:0] RESUME_MARK_RST  = 12'd4054;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH = 2'd0,
        CMD_POP  = 2'd1,
        CMD_END  = 2'd2,
        CMD_NOP  = 2'd3
    } cmd_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_INITIAL  = 3'd0,
        MODE_REFILL   = 3'd1,
        MODE_FLOWING  = 3'd2,
        MODE_FULL     = 3'd3,
        MODE_DRAINING = 3'd4,
        MODE_DONE     = 3'd5
    } mode_t;

    typedef enum logic {
        ST_IDLE,
        ST_FETCH
    } state_t;

    typedef struct packed {
        logic [MARK_W-1:0] initial_mark;
        logic [MARK_W-1:0] refill_mark;
        logic [MARK_W-1:0] resume_mark;
    } marks_t;

    typedef struct packed {
        logic              pop_ok;
        logic              push_ok;
        mode_t             mode;
        logic [FILL_W-1:0] fill;
    } step_t;

    typedef struct packed {
        logic              we;
        logic [AW-1:0]     waddr;
        logic [BYTE_W-1:0] wdata;
        logic              re;
        logic [AW-1:0]     raddr;
    } mem_req_t;

endpackage

// ===== hdl/bfwfc_ram.sv =====
module bfwfc_ram #(
    parameter int AW = 12,
    parameter int DW = 8
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    localparam int WORDS = 1 << AW;

    logic [DW-1:0] mem [WORDS];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/bfwfc_ctrl.sv =====
module bfwfc_ctrl (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             go,
    input  bfwfc_pkg::cmd_t                  cmd,
    input  logic [bfwfc_pkg::BYTE_W-1:0]     data_byte,
    input  bfwfc_pkg::marks_t                marks,
    output bfwfc_pkg::step_t                 step,
    output bfwfc_pkg::mem_req_t              mem
);

    logic [bfwfc_pkg::AW-1:0] in_idx_reg;
    logic [bfwfc_pkg::AW-1:0] in_idx_next;
    logic [bfwfc_pkg::AW-1:0] out_idx_reg;
    logic [bfwfc_pkg::AW-1:0] out_idx_next;
    logic [bfwfc_pkg::AW-1:0] held_reg;
    logic [bfwfc_pkg::AW-1:0] held_next;
    bfwfc_pkg::mode_t         mode_reg;
    bfwfc_pkg::mode_t         mode_next;
    logic [bfwfc_pkg::AW-1:0] held_inc;
    logic [bfwfc_pkg::AW-1:0] held_dec;
    logic                     push_ok;
    logic                     pop_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_idx_reg  <= '0;
            out_idx_reg <= '0;
            held_reg    <= '0;
            mode_reg    <= bfwfc_pkg::MODE_INITIAL;
        end
        else if (go)
        begin
            in_idx_reg  <= in_idx_next;
            out_idx_reg <= out_idx_next;
            held_reg    <= held_next;
            mode_reg    <= mode_next;
        end
    end

    always_comb
    begin
        mode_next    = mode_reg;
        held_next    = held_reg;
        in_idx_next  = in_idx_reg;
        out_idx_next = out_idx_reg;
        push_ok      = 1'b0;
        pop_ok       = 1'b0;
        held_inc     = held_reg + bfwfc_pkg::AW'(1);
        held_dec     = held_reg - bfwfc_pkg::AW'(1);
        case (cmd)
            bfwfc_pkg::CMD_PUSH:
            begin
                if (mode_reg == bfwfc_pkg::MODE_INITIAL || mode_reg == bfwfc_pkg::MODE_REFILL
                    || mode_reg == bfwfc_pkg::MODE_FLOWING)
                begin
                    if (held_reg >= bfwfc_pkg::LAST_SLOT)
                    begin
                        mode_next = bfwfc_pkg::MODE_FULL;
                    end
                    else
                    begin
                        push_ok     = 1'b1;
                        held_next   = held_inc;
                        in_idx_next = (in_idx_reg == bfwfc_pkg::LAST_SLOT) ? '0
                                      : in_idx_reg + bfwfc_pkg::AW'(1);
                        if (held_inc >= bfwfc_pkg::LAST_SLOT)
                        begin
                            mode_next = bfwfc_pkg::MODE_FULL;
                        end
                        else if (mode_reg == bfwfc_pkg::MODE_INITIAL
                                 && bfwfc_pkg::CMP_W'(held_inc)
                                    > bfwfc_pkg::CMP_W'(marks.initial_mark))
                        begin
                            mode_next = bfwfc_pkg::MODE_FLOWING;
                        end
                        else if (mode_reg == bfwfc_pkg::MODE_REFILL
                                 && bfwfc_pkg::CMP_W'(held_inc)
                                    > bfwfc_pkg::CMP_W'(marks.refill_mark))
                        begin
                            mode_next = bfwfc_pkg::MODE_FLOWING;
                        end
                    end
                end
            end
            bfwfc_pkg::CMD_POP:
            begin
                if (mode_reg == bfwfc_pkg::MODE_FLOWING || mode_reg == bfwfc_pkg::MODE_FULL
                    || mode_reg == bfwfc_pkg::MODE_DRAINING)
                begin
                    if (held_reg == '0)
                    begin
                        if (mode_reg == bfwfc_pkg::MODE_DRAINING)
                        begin
                            mode_next = bfwfc_pkg::MODE_DONE;
                        end
                    end
                    else
                    begin
                        pop_ok       = 1'b1;
                        held_next    = held_dec;
                        out_idx_next = (out_idx_reg == bfwfc_pkg::LAST_SLOT) ? '0
                                       : out_idx_reg + bfwfc_pkg::AW'(1);
                        if (held_dec == '0)
                        begin
                            mode_next = (mode_reg == bfwfc_pkg::MODE_DRAINING)
                                        ? bfwfc_pkg::MODE_DONE : bfwfc_pkg::MODE_REFILL;
                        end
                        else if (mode_reg == bfwfc_pkg::MODE_FULL
                                 && bfwfc_pkg::CMP_W'(held_dec)
                                    <= bfwfc_pkg::CMP_W'(marks.resume_mark))
                        begin
                            mode_next = bfwfc_pkg::MODE_FLOWING;
                        end
                    end
                end
            end
            bfwfc_pkg::CMD_END:
            begin
                if (mode_reg == bfwfc_pkg::MODE_INITIAL || mode_reg == bfwfc_pkg::MODE_REFILL
                    || mode_reg == bfwfc_pkg::MODE_FLOWING || mode_reg == bfwfc_pkg::MODE_FULL)
                begin
                    mode_next = (held_reg == '0) ? bfwfc_pkg::MODE_DONE
                                : bfwfc_pkg::MODE_DRAINING;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign step.pop_ok  = pop_ok;
    assign step.push_ok = push_ok;
    assign step.mode    = mode_next;
    assign step.fill    = bfwfc_pkg::FILL_W'(held_next);

    assign mem.we    = go && push_ok;
    assign mem.waddr = in_idx_reg;
    assign mem.wdata = data_byte;
    assign mem.re    = go && pop_ok;
    assign mem.raddr = out_idx_reg;

endmodule

// ===== hdl/byte_fifo_watermark_flow_control.sv =====
// Byte FIFO with watermark flow control. Each input word carries a command in s_tuser
// (push, pop, end of input, no-op) and a byte in s_tdata; each returns exactly one result
// word with the popped byte, push status, mode and fill level. A pop that takes a byte waits
// in the fetch state for the registered store read; other words are answered from idle. A new
// word is taken while the previous result is taken on the same edge. Marks must be written on
// cfg_we/cfg_index/cfg_data while the block is idle (not enforced); index 3 is ignored.
module byte_fifo_watermark_flow_control (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [bfwfc_pkg::BYTE_W-1:0]        s_tdata,    // [7:0] data_byte
    input  logic [bfwfc_pkg::CMD_W-1:0]         s_tuser,    // [1:0] command
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [0] out_valid, [8:1] out_byte, [9] push_taken, [12:10] mode, [24:13] fill_level
    output logic [bfwfc_pkg::OUT_W-1:0]         m_tdata,
    input  logic                                cfg_we,
    input  logic [bfwfc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bfwfc_pkg::MARK_W-1:0]        cfg_data
);

    bfwfc_pkg::marks_t                marks_reg;
    bfwfc_pkg::state_t                state_reg;
    bfwfc_pkg::state_t                state_next;
    logic                             m_valid_reg;
    logic                             m_valid_next;
    logic                             ov_reg;
    logic                             ov_next;
    logic [bfwfc_pkg::BYTE_W-1:0]     ob_reg;
    logic [bfwfc_pkg::BYTE_W-1:0]     ob_next;
    logic                             tk_reg;
    logic                             tk_next;
    bfwfc_pkg::mode_t                 md_reg;
    bfwfc_pkg::mode_t                 md_next;
    logic [bfwfc_pkg::FILL_W-1:0]     fl_reg;
    logic [bfwfc_pkg::FILL_W-1:0]     fl_next;
    logic                             go;
    bfwfc_pkg::step_t                 step;
    bfwfc_pkg::mem_req_t              mem;
    logic [bfwfc_pkg::BYTE_W-1:0]     rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marks_reg.initial_mark <= bfwfc_pkg::INITIAL_MARK_RST;
            marks_reg.refill_mark  <= bfwfc_pkg::REFILL_MARK_RST;
            marks_reg.resume_mark  <= bfwfc_pkg::RESUME_MARK_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bfwfc_pkg::REG_INITIAL_MARK: marks_reg.initial_mark <= cfg_data;
                bfwfc_pkg::REG_REFILL_MARK:  marks_reg.refill_mark  <= cfg_data;
                bfwfc_pkg::REG_RESUME_MARK:  marks_reg.resume_mark  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign s_tready = (state_reg == bfwfc_pkg::ST_IDLE) && (!m_valid_reg || m_tready);
    assign go       = s_tvalid && s_tready;

    bfwfc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (go),
        .cmd       (bfwfc_pkg::cmd_t'(s_tuser)),
        .data_byte (s_tdata),
        .marks     (marks_reg),
        .step      (step),
        .mem       (mem)
    );

    bfwfc_ram #(
        .AW (bfwfc_pkg::AW),
        .DW (bfwfc_pkg::BYTE_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem.we),
        .waddr (mem.waddr),
        .wdata (mem.wdata),
        .re    (mem.re),
        .raddr (mem.raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= bfwfc_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ov_reg <= ov_next;
        ob_reg <= ob_next;
        tk_reg <= tk_next;
        md_reg <= md_next;
        fl_reg <= fl_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        ov_next      = ov_reg;
        ob_next      = ob_reg;
        tk_next      = tk_reg;
        md_next      = md_reg;
        fl_next      = fl_reg;
        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            bfwfc_pkg::ST_IDLE:
            begin
                if (go)
                begin
                    ov_next = step.pop_ok;
                    ob_next = '0;
                    tk_next = step.push_ok;
                    md_next = step.mode;
                    fl_next = step.fill;
                    if (step.pop_ok)
                    begin
                        state_next = bfwfc_pkg::ST_FETCH;
                    end
                    else
                    begin
                        m_valid_next = 1'b1;
                    end
                end
            end
            bfwfc_pkg::ST_FETCH:
            begin
                ob_next      = rdata;
                m_valid_next = 1'b1;
                state_next   = bfwfc_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = bfwfc_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = bfwfc_pkg::OUT_W'({fl_reg, md_reg, tk_reg, ob_reg, ov_reg});

endmodule

// ===== hdl/bfwfc_chk.sv =====
`include "byte_fifo_watermark_flow_control_macros.svh"

module bfwfc_chk (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [bfwfc_pkg::OUT_W-1:0]  m_tdata
);

    logic                         out_valid_w;
    logic [bfwfc_pkg::BYTE_W-1:0] out_byte_w;
    logic                         push_taken_w;
    logic [bfwfc_pkg::MODE_W-1:0] mode_w;

    assign out_valid_w  = m_tdata[bfwfc_pkg::OV_BIT];
    assign out_byte_w   = m_tdata[bfwfc_pkg::OB_LSB +: bfwfc_pkg::BYTE_W];
    assign push_taken_w = m_tdata[bfwfc_pkg::TK_BIT];
    assign mode_w       = m_tdata[bfwfc_pkg::MD_LSB +: bfwfc_pkg::MODE_W];

    `BFWFC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    `BFWFC_ASSERT_NOW(a_no_take_when_stalled, m_tvalid && !m_tready, !s_tready)

    `BFWFC_ASSERT_NOW(a_idle_byte_zero, m_tvalid && !out_valid_w, out_byte_w == '0)

    `BFWFC_ASSERT_NOW(a_push_pop_excl, m_tvalid, !(out_valid_w && push_taken_w))

    `BFWFC_ASSERT_NOW(a_push_mode, m_tvalid && push_taken_w, mode_w < bfwfc_pkg::MODE_DRAINING)

endmodule

bind byte_fifo_watermark_flow_control bfwfc_chk u_bfwfc_chk (.*);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

    localparam int CAPACITY       = bfwfc_pkg::DEPTH - 1;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PHASES  = 5;
    localparam int PHASE_WORDS    = 100;
    localparam int END_WAIT       = 16;

    localparam logic [bfwfc_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam int END_WITH_DATA = 0;
    localparam int END_EMPTY     = 1;

    typedef struct packed {
        logic                         out_valid;
        logic [bfwfc_pkg::BYTE_W-1:0] out_byte;
        logic                         push_taken;
        bfwfc_pkg::mode_t             mode;
        logic [bfwfc_pkg::FILL_W-1:0] fill_level;
    } fifo_word_t;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [bfwfc_pkg::BYTE_W-1:0]    s_tdata   = '0;
    logic [bfwfc_pkg::CMD_W-1:0]     s_tuser   = bfwfc_pkg::CMD_NOP;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [bfwfc_pkg::OUT_W-1:0]     m_tdata;
    logic                            cfg_we    = 1'b0;
    logic [bfwfc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [bfwfc_pkg::MARK_W-1:0]    cfg_data  = '0;

    // fill model
    logic [bfwfc_pkg::BYTE_W-1:0] ring_mem [0:bfwfc_pkg::DEPTH-1];
    int                           wr_ptr       = 0;
    int                           rd_ptr       = 0;
    int                           held         = 0;
    bfwfc_pkg::mode_t             cur_mode     = bfwfc_pkg::MODE_INITIAL;
    logic [bfwfc_pkg::MARK_W-1:0] mark_initial = bfwfc_pkg::INITIAL_MARK_RST;
    logic [bfwfc_pkg::MARK_W-1:0] mark_refill  = bfwfc_pkg::REFILL_MARK_RST;
    logic [bfwfc_pkg::MARK_W-1:0] mark_resume  = bfwfc_pkg::RESUME_MARK_RST;

    fifo_word_t predicted_words [$];

    int burst_left   = 0;
    int fail_count   = 0;
    int words_sent   = 0;
    int words_seen   = 0;
    int bytes_stored = 0;
    int bytes_popped = 0;
    int end_path     = END_WITH_DATA;
    int idle_cycles  = 0;
    int ready_style  = 0;
    int ready_left   = 0;
    int ready_phase  = 0;

    byte_fifo_watermark_flow_control i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    task automatic step_fill_model(input bfwfc_pkg::cmd_t cmd,
                                   input logic [bfwfc_pkg::BYTE_W-1:0] data);
        fifo_word_t w;
        w.out_valid  = 1'b0;
        w.out_byte   = '0;
        w.push_taken = 1'b0;
        case (cmd)
            bfwfc_pkg::CMD_PUSH:
                if (cur_mode inside {bfwfc_pkg::MODE_INITIAL, bfwfc_pkg::MODE_REFILL,
                                     bfwfc_pkg::MODE_FLOWING})
                begin
                    if (held >= CAPACITY)
                    begin
                        cur_mode = bfwfc_pkg::MODE_FULL;
                    end
                    else
                    begin
                        ring_mem[wr_ptr] = data;
                        wr_ptr = (wr_ptr + 1) % bfwfc_pkg::DEPTH;
                        held++;
                        bytes_stored++;
                        w.push_taken = 1'b1;
                        if (held >= CAPACITY)
                            cur_mode = bfwfc_pkg::MODE_FULL;
                        else if (cur_mode == bfwfc_pkg::MODE_INITIAL && held > mark_initial)
                            cur_mode = bfwfc_pkg::MODE_FLOWING;
                        else if (cur_mode == bfwfc_pkg::MODE_REFILL && held > mark_refill)
                            cur_mode = bfwfc_pkg::MODE_FLOWING;
                    end
                end
            bfwfc_pkg::CMD_POP:
                if (cur_mode inside {bfwfc_pkg::MODE_FLOWING, bfwfc_pkg::MODE_FULL,
                                     bfwfc_pkg::MODE_DRAINING})
                begin
                    if (held == 0)
                    begin
                        if (cur_mode == bfwfc_pkg::MODE_DRAINING)
                            cur_mode = bfwfc_pkg::MODE_DONE;
                    end
                    else
                    begin
                        w.out_valid = 1'b1;
                        w.out_byte  = ring_mem[rd_ptr];
                        rd_ptr = (rd_ptr + 1) % bfwfc_pkg::DEPTH;
                        held--;
                        bytes_popped++;
                        if (held == 0)
                            cur_mode = (cur_mode == bfwfc_pkg::MODE_DRAINING) ?
                                       bfwfc_pkg::MODE_DONE : bfwfc_pkg::MODE_REFILL;
                        else if (cur_mode == bfwfc_pkg::MODE_FULL && held <= mark_resume)
                            cur_mode = bfwfc_pkg::MODE_FLOWING;
                    end
                end
            bfwfc_pkg::CMD_END:
                if (cur_mode inside {bfwfc_pkg::MODE_INITIAL, bfwfc_pkg::MODE_REFILL,
                                     bfwfc_pkg::MODE_FLOWING, bfwfc_pkg::MODE_FULL})
                    cur_mode = (held == 0) ? bfwfc_pkg::MODE_DONE : bfwfc_pkg::MODE_DRAINING;
            default:
                ;
        endcase
        w.mode       = cur_mode;
        w.fill_level = held[bfwfc_pkg::FILL_W-1:0];
        predicted_words.push_back(w);
    endtask

    task automatic send_word(input bfwfc_pkg::cmd_t cmd,
                             input logic [bfwfc_pkg::BYTE_W-1:0] data);
        int gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 24);
            if (gap > 0)
            begin
                @(negedge clk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= data;
        do @(posedge clk); while (!s_tready);
        step_fill_model(cmd, data);
        words_sent++;
        burst_left--;
    endtask

    task automatic send_random_byte(input bfwfc_pkg::cmd_t cmd);
        send_word(cmd, bfwfc_pkg::BYTE_W'($urandom_range(0, 255)));
    endtask

    // hold off until every word is out, then write one mark
    task automatic write_mark(input logic [bfwfc_pkg::CFG_IDX_W-1:0] idx,
                              input logic [bfwfc_pkg::MARK_W-1:0] val);
        @(negedge clk);
        s_tvalid   <= 1'b0;
        burst_left = 0;
        while (predicted_words.size() != 0) @(posedge clk);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            bfwfc_pkg::REG_INITIAL_MARK: mark_initial = val;
            bfwfc_pkg::REG_REFILL_MARK:  mark_refill  = val;
            bfwfc_pkg::REG_RESUME_MARK:  mark_resume  = val;
            default:                     ;
        endcase
    endtask

    task automatic test_directed();
        write_mark(bfwfc_pkg::REG_INITIAL_MARK, 12'd4);
        write_mark(bfwfc_pkg::REG_REFILL_MARK, 12'd0);
        write_mark(REG_UNUSED, 12'hFFF);
        send_word(bfwfc_pkg::CMD_POP, 8'h00);
        send_word(bfwfc_pkg::CMD_NOP, 8'hFF);
        send_word(bfwfc_pkg::CMD_PUSH, 8'h00);
        send_word(bfwfc_pkg::CMD_PUSH, 8'hFF);
        send_word(bfwfc_pkg::CMD_POP, 8'h00);
        send_word(bfwfc_pkg::CMD_PUSH, 8'hA5);
        send_word(bfwfc_pkg::CMD_PUSH, 8'h5A);
        send_word(bfwfc_pkg::CMD_PUSH, 8'h80);
        send_word(bfwfc_pkg::CMD_NOP, 8'h00);
        repeat (5) send_word(bfwfc_pkg::CMD_POP, 8'hFF);
        send_word(bfwfc_pkg::CMD_POP, 8'h00);
        send_word(bfwfc_pkg::CMD_PUSH, 8'h01);
        send_word(bfwfc_pkg::CMD_PUSH, 8'h7E);
        send_word(bfwfc_pkg::CMD_POP, 8'h00);
        send_word(bfwfc_pkg::CMD_POP, 8'h00);
    endtask

    task automatic test_random_traffic();
        int run_len;
        int bias;
        int pick;
        int sent;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase == 0)
                write_mark(bfwfc_pkg::REG_INITIAL_MARK, 12'd0);
            write_mark(bfwfc_pkg::REG_REFILL_MARK, (phase == RANDOM_PHASES - 1) ?
                       bfwfc_pkg::MARK_W'($urandom_range(25, 60)) :
                       bfwfc_pkg::MARK_W'($urandom_range(0, 24)));
            write_mark(bfwfc_pkg::REG_RESUME_MARK, (phase == 1) ? 12'd0 :
                       bfwfc_pkg::MARK_W'($urandom_range(0, 4095)));
            sent = 0;
            while (sent < PHASE_WORDS)
            begin
                run_len = $urandom_range(1, 16);
                bias    = (held > 150) ? 1 : $urandom_range(0, 2);
                repeat (run_len)
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 5)
                        send_random_byte(bfwfc_pkg::CMD_NOP);
                    else if ((bias == 0 && pick < 80) || (bias == 1 && pick >= 80) ||
                             (bias == 2 && pick < 52))
                        send_random_byte(bfwfc_pkg::CMD_PUSH);
                    else
                        send_random_byte(bfwfc_pkg::CMD_POP);
                    sent++;
                end
            end
        end
    endtask

    task automatic test_end_of_input();
        end_path = $urandom_range(END_WITH_DATA, END_EMPTY);
        if (end_path == END_EMPTY)
        begin
            while (held > 0) send_random_byte(bfwfc_pkg::CMD_POP);
        end
        send_random_byte(bfwfc_pkg::CMD_END);
        send_random_byte(bfwfc_pkg::CMD_PUSH);
        send_random_byte(bfwfc_pkg::CMD_END);
        send_random_byte(bfwfc_pkg::CMD_NOP);
        while (held > 0)
        begin
            case ($urandom_range(0, 19))
                0:       send_random_byte(bfwfc_pkg::CMD_PUSH);
                1:       send_random_byte(bfwfc_pkg::CMD_NOP);
                default: send_random_byte(bfwfc_pkg::CMD_POP);
            endcase
        end
        send_random_byte(bfwfc_pkg::CMD_POP);
        send_random_byte(bfwfc_pkg::CMD_PUSH);
        send_random_byte(bfwfc_pkg::CMD_END);
        send_random_byte(bfwfc_pkg::CMD_NOP);
    endtask

    // sink stall pattern
    always @(negedge clk)
    begin
        if (ready_left == 0)
        begin
            ready_style = $urandom_range(0, 2);
            ready_left  = $urandom_range(16, 96);
        end
        ready_left--;
        ready_phase++;
        case (ready_style)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 3) != 0);
            default: m_tready <= ((ready_phase % 6) >= 2);
        endcase
    end

    always @(posedge clk)
    begin : check_words
        fifo_word_t exp_w;
        if (rst_n && m_tvalid && m_tready)
        begin
            words_seen++;
            if (predicted_words.size() == 0)
            begin
                $error("unexpected result word %h", m_tdata);
                fail_count++;
            end
            else
            begin
                exp_w = predicted_words.pop_front();
                if (m_tdata[bfwfc_pkg::OV_BIT] !== exp_w.out_valid)
                begin
                    $error("out_valid: expected %0d actual %0d", exp_w.out_valid,
                           m_tdata[bfwfc_pkg::OV_BIT]);
                    fail_count++;
                end
                if (m_tdata[bfwfc_pkg::OB_LSB +: bfwfc_pkg::BYTE_W] !== exp_w.out_byte)
                begin
                    $error("out_byte: expected %0h actual %0h", exp_w.out_byte,
                           m_tdata[bfwfc_pkg::OB_LSB +: bfwfc_pkg::BYTE_W]);
                    fail_count++;
                end
                if (m_tdata[bfwfc_pkg::TK_BIT] !== exp_w.push_taken)
                begin
                    $error("push_taken: expected %0d actual %0d", exp_w.push_taken,
                           m_tdata[bfwfc_pkg::TK_BIT]);
                    fail_count++;
                end
                if (m_tdata[bfwfc_pkg::MD_LSB +: bfwfc_pkg::MODE_W] !== exp_w.mode)
                begin
                    $error("mode: expected %0d actual %0d", exp_w.mode,
                           m_tdata[bfwfc_pkg::MD_LSB +: bfwfc_pkg::MODE_W]);
                    fail_count++;
                end
                if (m_tdata[bfwfc_pkg::FL_LSB +: bfwfc_pkg::FILL_W] !== exp_w.fill_level)
                begin
                    $error("fill_level: expected %0d actual %0d", exp_w.fill_level,
                           m_tdata[bfwfc_pkg::FL_LSB +: bfwfc_pkg::FILL_W]);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_random_traffic();
        test_end_of_input();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (predicted_words.size() != 0) @(posedge clk);
        repeat (END_WAIT) @(posedge clk);
        $display("Sent %0d words, checked %0d results: %0d bytes stored, %0d returned",
                 words_sent, words_seen, bytes_stored, bytes_popped);
        $display("Mark changes between bursts; end of input taken %0s",
                 (end_path == END_EMPTY) ? "on an empty buffer" : "with data held");
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/bfwfc_pkg.sv
hdl/bfwfc_ram.sv
hdl/bfwfc_ctrl.sv
hdl/byte_fifo_watermark_flow_control.sv
hdl/bfwfc_chk.sv
tb/sv/tb_top.sv
